>>> rtl/core/ittf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter package
// Shared types, codes and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package ittf_pkg;

    localparam int unsigned IN_W  = 88;
    localparam int unsigned OUT_W = 24;
    localparam int unsigned MAX_FIELD_WIDTH = 64;
    localparam int unsigned MAX_DIGITS = 64;
    localparam int unsigned BCD_DIGITS = 20;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;
    localparam logic [1:0] RADIX_BIN = 2'd3;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_LAYOUT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
        logic layout;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dec;
        logic conv_done;
        logic scan_done;
        logic emit_last;
    } status_t;

endpackage

>>> rtl/core/ittf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter controller
// Sequences load, conversion, digit scan, layout and output beats.
// ----------------------------------------------------------------------------
module ittf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ittf_pkg::status_t  status,
    output ittf_pkg::cmd_t     cmd
);

    ittf_pkg::state_t state_reg;
    ittf_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ittf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ittf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ittf_pkg::ST_CONVERT;
                end
            end
            ittf_pkg::ST_CONVERT:
            begin
                if (!status.is_dec || status.conv_done)
                begin
                    state_next = ittf_pkg::ST_SCAN;
                end
            end
            ittf_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ittf_pkg::ST_LAYOUT;
                end
            end
            ittf_pkg::ST_LAYOUT:
            begin
                state_next = ittf_pkg::ST_EMIT;
            end
            ittf_pkg::ST_EMIT:
            begin
                if (cmd.emit && status.emit_last)
                begin
                    state_next = ittf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ittf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ittf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ittf_pkg::ST_CONVERT:
            begin
                cmd.conv_step = status.is_dec;
            end
            ittf_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ittf_pkg::ST_LAYOUT:
            begin
                cmd.layout = 1'b1;
            end
            ittf_pkg::ST_EMIT:
            begin
                cmd.emit = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ittf_pkg::ST_CONVERT)
        else $error("load did not start a conversion");

    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("beat written over a pending result");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.emit_last) |=> (state_reg == ittf_pkg::ST_IDLE && out_valid_reg))
        else $error("final beat did not end the operand");
`endif

endmodule

>>> rtl/core/ittf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter datapath
// Magnitude, decimal conversion, digit scan, layout and character generation.
// ----------------------------------------------------------------------------
module ittf_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ittf_pkg::cmd_t                  cmd,
    output ittf_pkg::status_t               status,
    input  logic [ittf_pkg::IN_W-1:0]       in_data,
    output logic [ittf_pkg::OUT_W-1:0]      out_data,
    output logic                            out_last
);

    // Operand settings held for the whole operand.
    logic [63:0] mag_reg, mag_next;
    logic [79:0] bcd_reg, bcd_next;
    logic [1:0]  radix_reg;
    logic        upper_reg, pgiven_reg, zpad_reg, left_reg, alt_reg, neg_reg;
    logic [6:0]  width_reg, prec_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  idx_reg;
    logic [6:0]  sig_reg;
    logic [6:0]  dcount_reg, pad_reg, tlen_reg, pos_reg;
    logic [1:0]  plen_reg;
    logic [ittf_pkg::OUT_W-1:0] out_reg;
    logic        last_reg;

    // Input unpacking.
    logic [63:0] in_raw;
    logic        in_sgn, in_upper, in_pgiven, in_zpad, in_left, in_alt;
    logic [1:0]  in_size, in_radix;
    logic [6:0]  in_width, in_prec;

    assign in_raw    = in_data[63:0];
    assign in_sgn    = in_data[64];
    assign in_size   = in_data[66:65];
    assign in_radix  = in_data[68:67];
    assign in_upper  = in_data[69];
    assign in_width  = in_data[76:70];
    assign in_pgiven = in_data[77];
    assign in_prec   = in_data[84:78];
    assign in_zpad   = in_data[85];
    assign in_left   = in_data[86];
    assign in_alt    = in_data[87];

    logic [63:0] v_trunc, v_mask, v_mag;
    logic        v_sbit, v_neg;
    logic [5:0]  scan_top;
    logic [3:0]  scan_digit;
    logic [6:0]  dcount_calc;
    logic [1:0]  plen_calc;
    logic [7:0]  body_calc;
    logic [6:0]  pad_calc;
    logic [7:0]  pos2;

    function automatic logic [3:0] digit_at(input logic [6:0] idx);
        logic [79:0] sh;
        logic [8:0]  amt;
        begin
            amt = '0;
            sh  = '0;
            unique case (radix_reg)
                ittf_pkg::RADIX_DEC:
                begin
                    amt = {idx, 2'b00};
                    sh  = bcd_reg >> amt;
                end
                ittf_pkg::RADIX_OCT:
                begin
                    amt = {1'b0, idx, 1'b0} + {2'b00, idx};
                    sh  = {16'd0, mag_reg} >> amt;
                    sh[79:3] = '0;
                end
                ittf_pkg::RADIX_HEX:
                begin
                    amt = {idx, 2'b00};
                    sh  = {16'd0, mag_reg} >> amt;
                end
                ittf_pkg::RADIX_BIN:
                begin
                    amt = {2'b00, idx};
                    sh  = {16'd0, mag_reg} >> amt;
                    sh[79:1] = '0;
                end
            endcase
            return sh[3:0];
        end
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        begin
            if (d < 4'd10)
            begin
                return 8'h30 + {4'd0, d};
            end
            else if (upper_reg)
            begin
                return 8'h37 + {4'd0, d};
            end
            else
            begin
                return 8'h57 + {4'd0, d};
            end
        end
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] k);
        begin
            if (neg_reg)
            begin
                return 8'h2D;
            end
            else if (k == 2'd0)
            begin
                return 8'h30;
            end
            else if (radix_reg == ittf_pkg::RADIX_HEX)
            begin
                return upper_reg ? 8'h58 : 8'h78;
            end
            else
            begin
                return upper_reg ? 8'h42 : 8'h62;
            end
        end
    endfunction

    // Character at text position p; zero beyond the end of the text.
    function automatic logic [7:0] char_at(input logic [7:0] p);
        logic [7:0] pl, pd, dl, tl, didx;
        begin
            pl   = {6'd0, plen_reg};
            pd   = {1'b0, pad_reg};
            dl   = {1'b0, dcount_reg};
            tl   = {1'b0, tlen_reg};
            didx = tl - 8'd1 - p;
            if (p >= tl)
            begin
                return 8'h00;
            end
            else if (left_reg)
            begin
                didx = pl + dl - 8'd1 - p;
                if (p < pl)
                begin
                    return prefix_char(p[1:0]);
                end
                else if (p < pl + dl)
                begin
                    return digit_char(digit_at(didx[6:0]));
                end
                else
                begin
                    return 8'h20;
                end
            end
            else if (zpad_reg && !pgiven_reg)
            begin
                if (p < pl)
                begin
                    return prefix_char(p[1:0]);
                end
                else if (p < pl + pd)
                begin
                    return 8'h30;
                end
                else
                begin
                    return digit_char(digit_at(didx[6:0]));
                end
            end
            else
            begin
                didx = p - pd;
                if (p < pd)
                begin
                    return 8'h20;
                end
                else if (p < pd + pl)
                begin
                    return prefix_char(didx[1:0]);
                end
                else
                begin
                    didx = tl - 8'd1 - p;
                    return digit_char(digit_at(didx[6:0]));
                end
            end
        end
    endfunction

    // Truncation, sign extension and magnitude.
    always_comb
    begin
        unique case (in_size)
            ittf_pkg::SIZE_8:  v_mask = 64'h0000_0000_0000_00FF;
            ittf_pkg::SIZE_16: v_mask = 64'h0000_0000_0000_FFFF;
            ittf_pkg::SIZE_32: v_mask = 64'h0000_0000_FFFF_FFFF;
            ittf_pkg::SIZE_64: v_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        unique case (in_size)
            ittf_pkg::SIZE_8:  v_sbit = in_raw[7];
            ittf_pkg::SIZE_16: v_sbit = in_raw[15];
            ittf_pkg::SIZE_32: v_sbit = in_raw[31];
            ittf_pkg::SIZE_64: v_sbit = in_raw[63];
        endcase
        unique case (in_radix)
            ittf_pkg::RADIX_DEC: scan_top = 6'd19;
            ittf_pkg::RADIX_OCT: scan_top = 6'd21;
            ittf_pkg::RADIX_HEX: scan_top = 6'd15;
            ittf_pkg::RADIX_BIN: scan_top = 6'd63;
        endcase
        v_trunc = in_raw & v_mask;
        v_neg   = in_sgn && (in_radix == ittf_pkg::RADIX_DEC) && v_sbit;
        v_mag   = v_neg ? (((~v_trunc) & v_mask) + 64'd1) : v_trunc;
    end

    // One double-dabble step: adjust each BCD digit of five or more, then shift.
    always_comb
    begin
        bcd_next = bcd_reg;
        for (int i = 0; i < ittf_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_next[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
        bcd_next = {bcd_next[78:0], mag_reg[63]};
        mag_next = {mag_reg[62:0], 1'b0};
    end

    // Layout from the scan result.
    always_comb
    begin
        if (sig_reg == 7'd0)
        begin
            dcount_calc = (pgiven_reg && prec_reg == 7'd0) ? 7'd0 : 7'd1;
        end
        else
        begin
            dcount_calc = sig_reg;
        end
        if (pgiven_reg && prec_reg > dcount_calc)
        begin
            dcount_calc = prec_reg;
        end
        if (neg_reg)
        begin
            plen_calc = 2'd1;
        end
        else if (!alt_reg || radix_reg == ittf_pkg::RADIX_DEC)
        begin
            plen_calc = 2'd0;
        end
        else if (radix_reg == ittf_pkg::RADIX_OCT)
        begin
            plen_calc = 2'd1;
        end
        else
        begin
            plen_calc = 2'd2;
        end
        body_calc = {1'b0, dcount_calc} + {6'd0, plen_calc};
        pad_calc  = ({1'b0, width_reg} > body_calc) ? (width_reg - body_calc[6:0]) : 7'd0;
    end

    always_comb
    begin
        scan_digit = digit_at({1'b0, idx_reg});
    end

    assign pos2 = {1'b0, pos_reg} + 8'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg    <= v_mag;
            bcd_reg    <= '0;
            radix_reg  <= in_radix;
            upper_reg  <= in_upper;
            pgiven_reg <= in_pgiven;
            zpad_reg   <= in_zpad;
            left_reg   <= in_left;
            alt_reg    <= in_alt;
            neg_reg    <= v_neg;
            width_reg  <= (in_width > 7'(ittf_pkg::MAX_FIELD_WIDTH)) ?
                          7'(ittf_pkg::MAX_FIELD_WIDTH) : in_width;
            prec_reg   <= (in_prec > 7'(ittf_pkg::MAX_DIGITS)) ?
                          7'(ittf_pkg::MAX_DIGITS) : in_prec;
            idx_reg    <= scan_top;
        end
        if (cmd.conv_step)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end
        if (cmd.scan_step)
        begin
            if (scan_digit != 4'd0)
            begin
                sig_reg <= {1'b0, idx_reg} + 7'd1;
            end
            else
            begin
                sig_reg <= 7'd0;
                if (idx_reg != 6'd0)
                begin
                    idx_reg <= idx_reg - 6'd1;
                end
            end
        end
        if (cmd.layout)
        begin
            dcount_reg <= dcount_calc;
            plen_reg   <= plen_calc;
            pad_reg    <= pad_calc;
            tlen_reg   <= body_calc[6:0] + pad_calc;
            pos_reg    <= 7'd0;
        end
        if (cmd.emit)
        begin
            out_reg[7:0]   <= char_at({1'b0, pos_reg});
            out_reg[15:8]  <= char_at({1'b0, pos_reg} + 8'd1);
            out_reg[16]    <= ({1'b0, pos_reg} + 8'd1) < {1'b0, tlen_reg};
            out_reg[23:17] <= status.emit_last ? tlen_reg : 7'd0;
            last_reg       <= status.emit_last;
            pos_reg        <= pos2[6:0];
        end
    end

    assign status.is_dec    = (radix_reg == ittf_pkg::RADIX_DEC);
    assign status.conv_done = (cnt_reg == 6'd63);
    assign status.scan_done = (scan_digit != 4'd0) || (idx_reg == 6'd0);
    assign status.emit_last = (pos2 >= {1'b0, tlen_reg});
    assign out_data         = out_reg;
    assign out_last         = last_reg;

endmodule

>>> rtl/core/integer_to_text_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter
// Formats one integer operand as printf-style ASCII text, two characters
// per output transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_axis    in         one operand with its format settings per transaction
//  m_axis    out        two characters per transaction, tlast on the final one
//
// Each operand is loaded, then converted to BCD by a 64-step double-dabble
// loop for decimal (the other radices pass the conversion state with no step),
// then scanned one digit per step from the top digit the radix can hold
// (20, 22, 16 or 64) down to the first nonzero digit or the lowest digit,
// laid out, and sent one output beat at a time (1 to 33 beats).
// The input is taken only between operands; the final beat may still wait in
// the output register while the next operand is loaded and converted.
// A stalled output holds the beat and stops the beat sequencer.
// Reset is asynchronous and active low and clears the control state only.
//
module integer_to_text_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from the lowest bit up: raw_value[63:0], is_signed, operand_size[1:0],
    // radix_select[1:0], upper_case, field_width[6:0], precision_given,
    // precision[6:0], pad_zeros, justify_left, base_prefix.
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from the lowest bit up: first_char[7:0], second_char[7:0],
    // second_valid, total_chars[6:0].
    output logic [23:0] m_axis_tdata,
    // tlast is last_of_run.
    output logic        m_axis_tlast
);

    // Commands and status that join the sequencer to the datapath.
    ittf_pkg::cmd_t    cmd;
    ittf_pkg::status_t status;

    ittf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the operand, the BCD digits, the layout counts and
    // the output beat register.
    ittf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

endmodule
